// File: hdl/dcl_pkg.sv
`default_nettype none
package dcl_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_WHEELBASE = 3'd0;
    localparam logic [2:0] REG_STEER_LIM = 3'd1;
    localparam logic [2:0] REG_SPEED_LIM = 3'd2;
    localparam logic [2:0] REG_ACCEL_LIM = 3'd3;
    localparam logic [2:0] REG_COMFORT   = 3'd4;
    localparam logic [2:0] REG_EMERG     = 3'd5;
    localparam logic [2:0] REG_TIMEOUT   = 3'd6;
    localparam logic [2:0] REG_LEAD      = 3'd7;

    // Item kinds
    localparam logic [1:0] OP_CMD  = 2'd0;
    localparam logic [1:0] OP_ODOM = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam int DT_CAP_US_DEF = 100000;
    localparam logic [23:0] TIMEOUT_RST = 24'd500000;
    localparam logic [15:0] LEAD_RST    = 16'd1000;

    // CORDIC geometry: angle in 2^-20 rad, vector in 2^-24
    localparam int CORDIC_STEPS = 20;
    localparam int ANG_W = 22;
    localparam int Z_W   = 24;
    localparam int XY_W  = 28;
    localparam logic signed [Z_W-1:0] PI_Q20      = 24'sd3294199;
    localparam logic signed [Z_W-1:0] HALF_PI_Q20 = 24'sd1647099;

    // Shared divider geometry
    localparam int DIVN_W = 54;
    localparam int DIVD_W = 44;

    localparam int MICRO = 1000000;
    localparam int HALF_MICRO = 500000;

    // floor(n / 1e6) = ((n >> 6) * V_RECIP) >> V_RECIP_SH for any n below 2^36
    localparam logic [30:0] V_RECIP    = 31'd1125899907;
    localparam int          V_RECIP_SH = 44;

    typedef enum logic [3:0] {
        ST_IDLE, ST_INTEG, ST_CLAMP, ST_VDIV, ST_VWAIT, ST_TAN, ST_TANWAIT,
        ST_SCALE, ST_PROD, ST_YDIV, ST_YWAIT, ST_OUT
    } state_t;

    // Arctangent of 2^-i in 2^-20 rad
    function automatic logic signed [Z_W-1:0] dcl_atan(input logic [4:0] i);
        logic signed [Z_W-1:0] r;
        case (i)
            5'd0:  r = 24'sd823550;
            5'd1:  r = 24'sd486170;
            5'd2:  r = 24'sd256879;
            5'd3:  r = 24'sd130396;
            5'd4:  r = 24'sd65451;
            5'd5:  r = 24'sd32757;
            5'd6:  r = 24'sd16383;
            5'd7:  r = 24'sd8192;
            5'd8:  r = 24'sd4096;
            5'd9:  r = 24'sd2048;
            5'd10: r = 24'sd1024;
            5'd11: r = 24'sd512;
            5'd12: r = 24'sd256;
            5'd13: r = 24'sd128;
            5'd14: r = 24'sd64;
            5'd15: r = 24'sd32;
            5'd16: r = 24'sd16;
            5'd17: r = 24'sd8;
            5'd18: r = 24'sd4;
            5'd19: r = 24'sd2;
            default: r = 24'sd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/dcl_cordic.sv
`default_nettype none
module dcl_cordic
    import dcl_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [ANG_W-1:0] angle,
    output logic                         done,
    output logic signed [XY_W-1:0]       x_out,
    output logic signed [XY_W-1:0]       y_out
);

    logic signed [XY_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic signed [Z_W-1:0]  z_in;
    logic [4:0]             i_reg;
    logic                   busy_reg, done_reg;
    logic signed [XY_W-1:0] xs, ys;

    // Fold the angle into +-pi/2
    always_comb begin
        z_in = Z_W'(angle);
        if (z_in > HALF_PI_Q20) begin
            z_in = z_in - PI_Q20;
        end else if (z_in < -HALF_PI_Q20) begin
            z_in = z_in + PI_Q20;
        end
    end

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;

    // Control: one rotation per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end else if (busy_reg) begin
                i_reg <= i_reg + 5'd1;
                if (i_reg == 5'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Rotate the vector
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= XY_W'(1) <<< 24;
            y_reg <= '0;
            z_reg <= z_in;
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - dcl_atan(i_reg);
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + dcl_atan(i_reg);
            end
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;

endmodule
`default_nettype wire

// File: hdl/dcl_divider.sv
`default_nettype none
module dcl_divider
    import dcl_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIVN_W-1:0] dividend,
    input  wire logic [DIVD_W-1:0] divisor,
    output logic                   busy,
    output logic                   done,
    output logic [DIVN_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIVN_W);

    logic [DIVD_W:0]   rem_reg;
    logic [DIVN_W-1:0] quo_reg;
    logic [DIVD_W-1:0] div_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg, done_reg;
    logic [DIVD_W:0]   rem_sh;
    logic              take;

    // One restoring step: shift in a dividend bit, subtract if it fits
    assign rem_sh = {rem_reg[DIVD_W-1:0], quo_reg[DIVN_W-1]};
    assign take   = rem_sh >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIVN_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= take ? (rem_sh - {1'b0, div_reg}) : rem_sh;
            quo_reg <= {quo_reg[DIVN_W-2:0], take};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// File: hdl/drive_command_limiter_watchdog_core.sv
// Drive command limiter with command watchdog.
// Input channel s_*: one item per handshake; s_tuser carries the kind (command,
// odometry, control tick), s_tdata the time stamp and the payload fields.
// Commands and odometry items give no result. A control
// tick after the first one, with positive dt, gives one result on m_*:
// speed setpoint, yaw rate and the watchdog flag.
// Tick work, in order: integrate and clamp, setpoint rounding by reciprocal
// multiply, CORDIC start and 20 rotations, products, bit-serial yaw division
// (one quotient bit per cycle), output register. With wheelbase zero the
// CORDIC and division are skipped; with a zero cosine the division is
// skipped. One item is in work at a time; s_tready is low while a tick is
// worked, so a new item is taken only once the tick is through.
// Configuration is a plain write port (cfg_we, cfg_addr, cfg_wdata); the user
// must write it only while the block is idle; the block does not enforce this.
// Reset (aresetn low, synchronous) clears all held state and restores the
// register defaults: timeout 500000 us, setpoint lead 1000 mm/s, others zero.
// A result waits in the output register while m_tready is low; the block
// finishes the next tick only up to that register and holds there.
`default_nettype none
module drive_command_limiter_watchdog_core
    import dcl_pkg::*;
#(
    parameter int DT_CAP_US = DT_CAP_US_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // time_us[39:0], steer_cmd[55:40], accel_cmd[71:56], cmd_finite[72],
    // measured_speed[89:73], zero[95:90]
    input  wire logic [95:0] s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // speed_setpoint[15:0], yaw_cmd[31:16], watchdog_active[32], zero[39:33]
    output logic [39:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [23:0] cfg_wdata
);

    localparam int DT_W   = $clog2(DT_CAP_US + 1);
    localparam int PROD_W = 17 + DT_W + 1;
    localparam int ACC_W  = (PROD_W + 1 > 38) ? PROD_W + 1 : 38;

    // Configuration registers
    logic [15:0] wheelbase_reg, speed_lim_reg, lead_reg;
    logic [14:0] steer_lim_reg, accel_lim_reg, comfort_reg, emerg_reg;
    logic [23:0] timeout_reg;

    // Held state
    logic signed [15:0] held_steer_reg, held_accel_reg;
    logic [39:0]        last_cmd_reg, last_tick_reg;
    logic               cmd_seen_reg, tick_seen_reg;
    logic signed [16:0] odom_reg;
    logic [ACC_W-1:0]   acc_reg;

    // Per-tick work registers
    state_t                    state_reg, state_next;
    logic [DT_W-1:0]           dt_reg;
    logic signed [16:0]        accel_use_reg;
    logic signed [15:0]        steer_use_reg;
    logic                      wd_reg;
    logic signed [ACC_W-1:0]   sum_reg;
    logic [36:0]               hib_reg;
    logic                      hineg_reg;
    logic [29:0]               vm_reg;
    logic [15:0]               v_reg;
    logic [25:0]               v1000_reg;
    logic signed [XY_W-1:0]    x_reg, y_reg;
    logic signed [54:0]        num_reg;
    logic signed [44:0]        den_reg;
    logic signed [15:0]        yaw_reg;
    logic                      m_valid_reg;
    logic [39:0]               m_data_reg;

    // Input fields
    logic [39:0]        in_time;
    logic signed [15:0] in_steer, in_accel;
    logic               in_finite;
    logic signed [16:0] in_speed;
    logic               accept;

    assign in_time   = s_tdata[39:0];
    assign in_steer  = s_tdata[55:40];
    assign in_accel  = s_tdata[71:56];
    assign in_finite = s_tdata[72];
    assign in_speed  = s_tdata[89:73];
    assign accept    = s_tvalid && s_tready;

    // Decode helpers for the accept cycle
    logic signed [15:0] lim_s, steer_clip, acc_hi, acc_lo, accel_clip;
    logic signed [40:0] dt_full, age;
    logic               wd_now;
    logic [DT_W-1:0]    dt_cap;

    always_comb begin
        lim_s      = signed'({1'b0, steer_lim_reg});
        steer_clip = in_steer;
        if (steer_clip > lim_s) begin
            steer_clip = lim_s;
        end else if (steer_clip < -lim_s) begin
            steer_clip = -lim_s;
        end
        acc_hi     = signed'({1'b0, accel_lim_reg});
        acc_lo     = -signed'({1'b0, emerg_reg});
        accel_clip = in_accel;
        if (accel_clip > acc_hi) begin
            accel_clip = acc_hi;
        end else if (accel_clip < acc_lo) begin
            accel_clip = acc_lo;
        end
        dt_full = signed'({1'b0, in_time}) - signed'({1'b0, last_tick_reg});
        age     = signed'({1'b0, in_time}) - signed'({1'b0, last_cmd_reg});
        wd_now  = !cmd_seen_reg || (age > signed'({17'd0, timeout_reg}));
        if (dt_full > 41'sd0 + 41'(DT_CAP_US)) begin
            dt_cap = DT_W'(DT_CAP_US);
        end else begin
            dt_cap = dt_full[DT_W-1:0];
        end
    end

    // Integration and bound products
    logic signed [PROD_W-1:0] prod;
    logic signed [17:0]       hi_sum, hi_min;

    always_comb begin
        prod   = accel_use_reg * signed'({1'b0, dt_reg});
        hi_sum = signed'({odom_reg[16], odom_reg}) + signed'({2'b0, lead_reg});
        hi_min = hi_sum;
        if (signed'({2'b0, speed_lim_reg}) < hi_sum) begin
            hi_min = signed'({2'b0, speed_lim_reg});
        end
    end

    // Setpoint rounding: add half, drop 2^6, multiply by the reciprocal of 15625
    logic [ACC_W-1:0] vsum;
    logic [60:0]      vprod;

    assign vsum  = acc_reg + ACC_W'(HALF_MICRO);
    assign vprod = vm_reg * V_RECIP;

    // Shared units
    logic              div_start, div_busy, div_done;
    logic [DIVN_W-1:0] div_n, div_q;
    logic [DIVD_W-1:0] div_d;
    logic              cor_start, cor_done;
    logic signed [XY_W-1:0] cor_x, cor_y;
    logic [53:0]       num_mag;
    logic [43:0]       den_mag;
    logic              yneg;

    assign num_mag = num_reg[54] ? 54'(-num_reg) : num_reg[53:0];
    assign den_mag = den_reg[44] ? 44'(-den_reg) : den_reg[43:0];
    assign yneg    = num_reg[54] ^ den_reg[44];
    assign div_n   = num_mag;
    assign div_d   = den_mag;

    dcl_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    dcl_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .angle   (ANG_W'(steer_use_reg) <<< 6),
        .done    (cor_done),
        .x_out   (cor_x),
        .y_out   (cor_y)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_tuser == OP_TICK && tick_seen_reg
                    && dt_full > 41'sd0) begin
                    state_next = ST_INTEG;
                end
            end
            ST_INTEG:   state_next = ST_CLAMP;
            ST_CLAMP:   state_next = ST_VDIV;
            ST_VDIV:    state_next = ST_VWAIT;
            ST_VWAIT:   state_next = (wheelbase_reg == 16'd0) ? ST_OUT : ST_TAN;
            ST_TAN:     state_next = ST_TANWAIT;
            ST_TANWAIT: if (cor_done) state_next = ST_SCALE;
            ST_SCALE:   state_next = ST_PROD;
            ST_PROD:    state_next = ST_YDIV;
            ST_YDIV:    state_next = (den_reg == '0) ? ST_OUT : ST_YWAIT;
            ST_YWAIT:   if (div_done) state_next = ST_OUT;
            ST_OUT:     if (!m_valid_reg) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        cor_start = (state_reg == ST_TAN);
        div_start = (state_reg == ST_YDIV) && (den_reg != '0);
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            wheelbase_reg  <= '0;
            steer_lim_reg  <= '0;
            speed_lim_reg  <= '0;
            accel_lim_reg  <= '0;
            comfort_reg    <= '0;
            emerg_reg      <= '0;
            timeout_reg    <= TIMEOUT_RST;
            lead_reg       <= LEAD_RST;
            held_steer_reg <= '0;
            held_accel_reg <= '0;
            last_cmd_reg   <= '0;
            cmd_seen_reg   <= 1'b0;
            odom_reg       <= '0;
            last_tick_reg  <= '0;
            tick_seen_reg  <= 1'b0;
            acc_reg        <= '0;
        end else begin
            state_reg <= state_next;
            // Write configuration
            if (cfg_we) begin
                case (cfg_addr)
                    REG_WHEELBASE: wheelbase_reg <= cfg_wdata[15:0];
                    REG_STEER_LIM: steer_lim_reg <= cfg_wdata[14:0];
                    REG_SPEED_LIM: speed_lim_reg <= cfg_wdata[15:0];
                    REG_ACCEL_LIM: accel_lim_reg <= cfg_wdata[14:0];
                    REG_COMFORT:   comfort_reg   <= cfg_wdata[14:0];
                    REG_EMERG:     emerg_reg     <= cfg_wdata[14:0];
                    REG_TIMEOUT:   timeout_reg   <= cfg_wdata;
                    REG_LEAD:      lead_reg      <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            // Take an item
            if (accept) begin
                case (s_tuser)
                    OP_CMD: begin
                        if (in_finite) begin
                            held_steer_reg <= steer_clip;
                            held_accel_reg <= accel_clip;
                            last_cmd_reg   <= in_time;
                            cmd_seen_reg   <= 1'b1;
                        end
                    end
                    OP_ODOM: odom_reg <= in_speed;
                    OP_TICK: begin
                        tick_seen_reg <= 1'b1;
                        last_tick_reg <= in_time;
                    end
                    default: ;
                endcase
            end
            // Clamp the integrated speed
            if (state_reg == ST_CLAMP) begin
                if (hineg_reg || sum_reg < 0) begin
                    acc_reg <= '0;
                end else if (sum_reg > signed'(ACC_W'(hib_reg))) begin
                    acc_reg <= ACC_W'(hib_reg);
                end else begin
                    acc_reg <= sum_reg;
                end
            end
            // Hand over the result
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end else if (state_reg == ST_OUT && !m_valid_reg) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && accept) begin
            dt_reg        <= dt_cap;
            wd_reg        <= wd_now;
            accel_use_reg <= wd_now ? -signed'({2'b0, comfort_reg})
                                    : 17'(held_accel_reg);
            steer_use_reg <= wd_now ? 16'sd0 : held_steer_reg;
        end
        if (state_reg == ST_INTEG) begin
            sum_reg   <= signed'(acc_reg) + ACC_W'(prod);
            hib_reg   <= hi_min[16:0] * 20'(MICRO);
            hineg_reg <= hi_min[17];
        end
        if (state_reg == ST_VDIV) begin
            vm_reg <= vsum[35:6];
        end
        if (state_reg == ST_VWAIT) begin
            v_reg   <= vprod[V_RECIP_SH+15:V_RECIP_SH];
            yaw_reg <= '0;
        end
        if (state_reg == ST_TANWAIT && cor_done) begin
            x_reg <= cor_x;
            y_reg <= cor_y;
        end
        if (state_reg == ST_SCALE) begin
            v1000_reg <= v_reg * 10'd1000;
        end
        if (state_reg == ST_PROD) begin
            num_reg <= signed'({1'b0, v1000_reg}) * y_reg;
            den_reg <= signed'({1'b0, wheelbase_reg}) * x_reg;
        end
        // Saturate by the numerator sign when the cosine vanishes
        if (state_reg == ST_YDIV && den_reg == '0) begin
            if (num_reg > 0) begin
                yaw_reg <= 16'sd32767;
            end else if (num_reg < 0) begin
                yaw_reg <= -16'sd32768;
            end else begin
                yaw_reg <= '0;
            end
        end
        if (state_reg == ST_YWAIT && div_done) begin
            if (yneg) begin
                yaw_reg <= (div_q > 54'd32768) ? -16'sd32768 : -signed'(div_q[15:0]);
            end else begin
                yaw_reg <= (div_q > 54'd32767) ? 16'sd32767 : signed'(div_q[15:0]);
            end
        end
        if (state_reg == ST_OUT && !m_valid_reg) begin
            m_data_reg <= {7'd0, wd_reg, yaw_reg, v_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_no_result_from_other: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tuser != OP_TICK && !m_tvalid |=> !m_tvalid)
        else $error("result after a non-tick item");
    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_accum_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        !acc_reg[ACC_W-1])
        else $error("speed accumulator negative");
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_INTEG |-> $past(accept) && !s_tready)
        else $error("tick work without an accepted item");
`endif

endmodule
`default_nettype wire
